// ----- sv/ofo_pkg.sv -----
// Shared constants, types and helper functions of the oversampled FM oscillator.
package ofo_pkg;

   localparam int PHASE_BITS_DEF = 32;
   localparam int MAX_OVERSAMPLE = 16;
   localparam int IDX_W = 4;
   localparam int MUL_W = 33;
   localparam int DIV_N = 64;
   localparam int DIV_D = 44;

   localparam logic [1:0] WAVE_SINE   = 2'd0;
   localparam logic [1:0] WAVE_TRI    = 2'd1;
   localparam logic [1:0] WAVE_SAW    = 2'd2;
   localparam logic [1:0] WAVE_SQUARE = 2'd3;

   localparam logic [1:0] REG_WAVEFORM      = 2'd0;
   localparam logic [1:0] REG_QUALITY       = 2'd1;
   localparam logic [1:0] REG_FREQ_MULT     = 2'd2;
   localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd3;

   localparam logic [23:0] MIN_WIDTH     = 24'd33554;
   localparam logic [23:0] MAX_WIDTH     = 24'hFF_FFFF;
   localparam logic [15:0] WIDTH_DIVISOR = 16'd35000;
   // floor(2^47 / 35000), reciprocal for the width quotient
   localparam logic [31:0] WIDTH_RECIP   = 32'd4021071095;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // sine series coefficients, Q30
   function automatic logic signed [MUL_W-1:0] sin_coef(input logic [2:0] k);
      logic signed [MUL_W-1:0] c;
      case (k)
         3'd0:    c = 33'sd1686629713;
         3'd1:    c = 33'sd693598668;
         3'd2:    c = 33'sd85569306;
         3'd3:    c = 33'sd5026993;
         3'd4:    c = 33'sd172272;
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic logic [23:0] sat24(input logic signed [2*MUL_W-1:0] v);
      logic [23:0] r;
      if (v > $signed(66'sd8388607)) begin
         r = 24'h7F_FFFF;
      end else if (v < -$signed(66'sd8388608)) begin
         r = 24'h80_0000;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

endpackage

// ----- sv/ofo_mul.sv -----
// Shared signed multiplier with a registered product.
module ofo_mul
   import ofo_pkg::*;
(
   input  logic                          clock,
   input  logic signed [MUL_W-1:0]       op_a,
   input  logic signed [MUL_W-1:0]       op_b,
   output logic signed [2*MUL_W-1:0]     prod_ff
);

   logic signed [2*MUL_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ----- sv/ofo_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
module ofo_div
   import ofo_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_N-1:0] dividend,
   input  logic [DIV_D-1:0] divisor,
   output div_status_type   status,
   output logic [DIV_N-1:0] quotient
);

   localparam int CNT_W = $clog2(DIV_N);

   logic [DIV_D:0]   rem_ff, rem_in, rem_sh;
   logic [DIV_N-1:0] quo_ff, quo_in;
   logic [DIV_D-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[DIV_D-1:0], quo_ff[DIV_N-1]};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_in = rem_sh - {1'b0, dsr_ff};
            quo_in = {quo_ff[DIV_N-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[DIV_N-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_N - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

// ----- sv/oversampled_fm_oscillator_top.sv -----
// Oversampled FM oscillator: sequencer and datapath around a shared multiplier and divider.
// Each accepted word is one subsample; the block is busy until its result is registered.
// The first subsample of a frame also forms the step products and the reciprocal width
// quotient. Saw and square time is set by the 64-step radix-2 divider that forms the
// polynomial quotient, and by the single 33x33 multiplier that every product goes
// through. A finished result waits in the output register, and the next word is
// accepted while it waits.
module oversampled_fm_oscillator_top
   import ofo_pkg::*;
#(
   parameter int PHASE_BITS = PHASE_BITS_DEF
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [23:0]        req_frequency,
   input  logic signed [31:0] req_phase_mod,
   input  logic               req_restart,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [23:0] rsp_sample,
   output logic signed [23:0] rsp_fm_sample,
   output logic               rsp_last,
   output logic               rsp_wrapped
);

   localparam int PB = PHASE_BITS;
   localparam int OFF_W = PB + IDX_W;
   localparam int MAX_SHIFT = $clog2(MAX_OVERSAMPLE + 1) - 1;

   typedef enum logic [11:0] {
      S_IDLE   = 12'b0000_0000_0001,
      S_STEP   = 12'b0000_0000_0010,
      S_WSTART = 12'b0000_0000_0100,
      S_WDIV   = 12'b0000_0000_1000,
      S_PHASE  = 12'b0000_0001_0000,
      S_SINE   = 12'b0000_0010_0000,
      S_FMUL   = 12'b0000_0100_0000,
      S_POLY   = 12'b0000_1000_0000,
      S_DEN    = 12'b0001_0000_0000,
      S_QSTART = 12'b0010_0000_0000,
      S_QDIV   = 12'b0100_0000_0000,
      S_FIN    = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [2:0]  cnt_ff, cnt_in;
   logic [2:0]  term_ff, term_in;
   logic [1:0]  waveform_ff, waveform_in;
   logic [2:0]  quality_ff, quality_in;
   logic [23:0] fmult_ff, fmult_in;
   logic [31:0] period_ff, period_in;
   logic [23:0] freq_ff, freq_in;
   logic [31:0] pm_ff, pm_in;
   logic        restart_ff, restart_in;
   logic [PB-1:0] phase_ff, phase_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [PB-1:0] step_ff, step_in;
   logic [23:0] width_ff, width_in;
   logic [OFF_W-1:0] off_acc_ff, off_acc_in;
   logic [47:0] fm_ff, fm_in;
   logic [79:0] prod_ff, prod_in;
   logic [24:0] wq_ff, wq_in;
   logic [PB-1:0] p_ff, p_in;
   logic signed [MUL_W-1:0] t2_ff, t2_in;
   logic signed [20:0] ah_ff, ah_in;
   logic signed [63:0] num_ff, num_in;
   logic [42:0] den_ff, den_in;
   logic [23:0] main_ff, main_in;
   logic [23:0] fmv_ff, fmv_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_sample_ff, rsp_sample_in;
   logic [23:0] rsp_fm_ff, rsp_fm_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_wrapped_ff, rsp_wrapped_in;

   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [2*MUL_W-1:0] mul_p;
   logic                      div_start;
   logic [DIV_N-1:0]          div_dividend, div_quo;
   logic [DIV_D-1:0]          div_divisor;
   div_status_type            div_st;

   logic [2:0]       shift;
   logic [OFF_W-1:0] off_base, off;
   logic [71:0]      pm_wide;
   logic [PB-1:0]    pmq, p_sum;
   logic [PB+29:0]   p_wide;
   logic [29:0]      p30, q30;
   logic [19:0]      p20, nf, nf_raw, term_v;
   logic signed [33:0] sdiff, sabs, t_sin;
   logic signed [23:0] tdiff, tabs, tri_v;
   logic signed [21:0] d_v, dabs, d_rest, vm1, c_v;
   logic [20:0]      saw_rest;
   logic signed [MUL_W-1:0] r_val;
   logic             neg2;
   logic [79:0]      prod_full;
   logic [40:0]      wrem;
   logic [24:0]      wq_fix;
   logic [42:0]      nn;
   logic [63:0]      num_abs;
   logic signed [63:0] part;
   logic             fin_go, last_v, wrap_v;
   logic [PB-1:0]    phase_adv;

   function automatic logic [23:0] sat_quo(input logic neg, input logic [DIV_N-1:0] q);
      logic [23:0] r;
      if (!neg) begin
         r = (q > DIV_N'(8388607)) ? 24'h7F_FFFF : q[23:0];
      end else begin
         r = (q > DIV_N'(8388608)) ? 24'h80_0000 : 24'(-q);
      end
      return r;
   endfunction

   ofo_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (mul_p)
   );

   ofo_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_st),
      .quotient (div_quo)
   );

   // derived phase and waveform terms
   always_comb begin
      shift = (quality_ff <= 3'd4) ? quality_ff : 3'd0;
      if (shift > 3'(MAX_SHIFT)) begin
         shift = 3'(MAX_SHIFT);
      end
   end

   assign off_base = (idx_ff == '0) ? '0 : off_acc_ff;
   assign off      = off_base >> shift;
   assign pm_wide  = {pm_ff, 40'd0} >> (64 - PB);
   assign pmq      = pm_wide[PB-1:0];
   assign p_sum    = phase_ff + off[PB-1:0] + pmq;
   assign p_wide   = {p_ff, 30'd0} >> PB;
   assign p30      = p_wide[29:0];
   assign p20      = p30[29:10];
   assign q30      = p30 + 30'h1000_0000;
   assign sdiff    = 34'sh0_8000_0000 - $signed({2'b00, q30, 2'b00});
   assign sabs     = (sdiff < 0) ? -sdiff : sdiff;
   assign t_sin    = 34'sh0_4000_0000 - sabs;
   assign tdiff    = 24'sh20_0000 - $signed({2'b00, p20, 2'b00});
   assign tabs     = (tdiff < 0) ? -tdiff : tdiff;
   assign tri_v    = 24'sh10_0000 - tabs;
   assign d_v      = $signed({1'b0, p20, 1'b0}) - 22'sh10_0000;
   assign dabs     = (d_v < 0) ? -d_v : d_v;
   assign d_rest   = 22'sh10_0000 - dabs;
   assign saw_rest = 21'h10_0000 - {1'b0, p20};
   assign nf_raw   = width_ff[23:4];
   assign nf       = (nf_raw == '0) ? 20'd1 : nf_raw;

   always_comb begin
      case (term_ff)
         3'd0:    term_v = p20 - nf;
         3'd1:    term_v = p20 + nf;
         3'd2:    term_v = p20;
         3'd3:    term_v = 20'h8_0000 - p20 - nf;
         3'd4:    term_v = 20'h8_0000 - p20 + nf;
         default: term_v = 20'h8_0000 - p20;
      endcase
   end

   assign vm1       = $signed({2'b00, term_v}) - 22'sh10_0000;
   assign c_v       = $signed({1'b0, term_v, 1'b0}) - 22'sh10_0000;
   assign neg2      = (term_ff == 3'd2) || (term_ff == 3'd5);
   assign r_val     = sin_coef(3'd5 - cnt_ff) - MUL_W'(mul_p >>> 30);
   assign prod_full = prod_ff + (80'(mul_p[55:0]) << 24);
   // reciprocal estimate is exact or one low; the remainder decides
   assign wrem      = {1'b0, fm_ff[39:0]} - {1'b0, mul_p[39:0]};
   assign wq_fix    = wq_ff + {24'd0, (wrem >= 41'(WIDTH_DIVISOR))};
   assign nn        = {2'b00, mul_p[40:0]};
   assign num_abs   = num_ff[63] ? 64'(-num_ff) : 64'(num_ff);
   assign part      = (cnt_ff == 3'd3) ? (64'(mul_p) <<< 20) : 64'(mul_p);

   assign fin_go    = (state_ff == S_FIN) && (!rsp_valid_ff || !rsp_stall);
   assign last_v    = ({1'b0, idx_ff} + 5'd1) >= (5'd1 << shift);
   assign phase_adv = phase_ff + step_ff;
   assign wrap_v    = phase_adv < step_ff;

   assign div_start    = (state_ff == S_QSTART);
   assign div_dividend = num_abs;
   assign div_divisor  = DIV_D'(den_ff);

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_STEP: begin
            case (cnt_ff)
               3'd0: begin
                  mul_a = MUL_W'(freq_ff);
                  mul_b = MUL_W'(fmult_ff);
               end
               3'd1: begin
                  mul_a = MUL_W'(mul_p[23:0]);
                  mul_b = MUL_W'(period_ff);
               end
               default: begin
                  mul_a = MUL_W'(fm_ff[47:24]);
                  mul_b = MUL_W'(period_ff);
               end
            endcase
         end
         S_WSTART: begin
            mul_a = MUL_W'(fm_ff[39:8]);
            mul_b = MUL_W'(WIDTH_RECIP);
         end
         S_WDIV: begin
            mul_a = MUL_W'(mul_p[63:39]);
            mul_b = MUL_W'(WIDTH_DIVISOR);
         end
         S_SINE: begin
            if (cnt_ff == 3'd0) begin
               mul_a = MUL_W'(t_sin);
               mul_b = MUL_W'(t_sin);
            end else if (cnt_ff == 3'd1) begin
               mul_a = MUL_W'(mul_p >>> 30);
               mul_b = sin_coef(3'd4);
            end else if (cnt_ff == 3'd5) begin
               mul_a = MUL_W'(t_sin);
               mul_b = r_val;
            end else begin
               mul_a = t2_ff;
               mul_b = r_val;
            end
         end
         S_FMUL: begin
            if (waveform_ff == WAVE_TRI) begin
               mul_a = MUL_W'(d_v);
               mul_b = MUL_W'(d_rest);
            end else begin
               mul_a = MUL_W'(p20);
               mul_b = MUL_W'(saw_rest);
            end
         end
         S_POLY: begin
            case (cnt_ff)
               3'd0: begin
                  mul_a = MUL_W'(vm1);
                  mul_b = MUL_W'(term_v);
               end
               3'd1: begin
                  mul_a = MUL_W'(mul_p[19:0]);
                  mul_b = MUL_W'(c_v);
               end
               default: begin
                  mul_a = MUL_W'(ah_ff);
                  mul_b = MUL_W'(c_v);
               end
            endcase
         end
         S_DEN: begin
            mul_a = MUL_W'(nf);
            mul_b = MUL_W'(nf);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer and datapath registers
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      term_in        = term_ff;
      waveform_in    = waveform_ff;
      quality_in     = quality_ff;
      fmult_in       = fmult_ff;
      period_in      = period_ff;
      freq_in        = freq_ff;
      pm_in          = pm_ff;
      restart_in     = restart_ff;
      phase_in       = phase_ff;
      idx_in         = idx_ff;
      step_in        = step_ff;
      width_in       = width_ff;
      off_acc_in     = off_acc_ff;
      fm_in          = fm_ff;
      prod_in        = prod_ff;
      wq_in          = wq_ff;
      p_in           = p_ff;
      t2_in          = t2_ff;
      ah_in          = ah_ff;
      num_in         = num_ff;
      den_in         = den_ff;
      main_in        = main_ff;
      fmv_in         = fmv_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_sample_in  = rsp_sample_ff;
      rsp_fm_in      = rsp_fm_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_wrapped_in = rsp_wrapped_ff;

      if (csr_we) begin
         unique case (csr_index)
            REG_WAVEFORM:      waveform_in = csr_wdata[1:0];
            REG_QUALITY:       quality_in  = csr_wdata[2:0];
            REG_FREQ_MULT:     fmult_in    = csr_wdata[23:0];
            REG_SAMPLE_PERIOD: period_in   = csr_wdata;
            default:           waveform_in = waveform_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               freq_in    = req_frequency;
               pm_in      = req_phase_mod;
               restart_in = req_restart;
               cnt_in     = '0;
               state_in   = (idx_ff == '0) ? S_STEP : S_PHASE;
            end
         end
         S_STEP: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd1) begin
               fm_in = mul_p[47:0];
            end else if (cnt_ff == 3'd2) begin
               prod_in = 80'(mul_p[55:0]);
            end else if (cnt_ff == 3'd3) begin
               // saturate a step of a whole phase turn or more
               step_in = (prod_full[79:64] != '0) ? '1 : prod_full[63 -: PB];
               if (restart_ff) begin
                  phase_in = '0;
               end
               state_in = S_WSTART;
            end
         end
         S_WSTART: begin
            cnt_in   = '0;
            state_in = S_WDIV;
         end
         S_WDIV: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd0) begin
               wq_in = mul_p[63:39];
            end else begin
               if (fm_ff[47:40] != '0) begin
                  width_in = MAX_WIDTH;
               end else if (wq_fix < 25'(MIN_WIDTH)) begin
                  width_in = MIN_WIDTH;
               end else if (wq_fix > 25'(MAX_WIDTH)) begin
                  width_in = MAX_WIDTH;
               end else begin
                  width_in = wq_fix[23:0];
               end
               state_in = S_PHASE;
            end
         end
         S_PHASE: begin
            p_in    = p_sum;
            cnt_in  = '0;
            term_in = '0;
            num_in  = '0;
            case (waveform_ff)
               WAVE_SINE:          state_in = S_SINE;
               WAVE_TRI, WAVE_SAW: state_in = S_FMUL;
               default:            state_in = S_POLY;
            endcase
         end
         S_SINE: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd1) begin
               t2_in = MUL_W'(mul_p >>> 30);
            end else if (cnt_ff == 3'd6) begin
               main_in  = sat24(mul_p >>> 40);
               fmv_in   = sat24(mul_p >>> 40);
               state_in = S_FIN;
            end
         end
         S_FMUL: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd1) begin
               cnt_in = '0;
               if (waveform_ff == WAVE_TRI) begin
                  main_in  = tri_v;
                  fmv_in   = sat24(mul_p >>> 19);
                  state_in = S_FIN;
               end else begin
                  fmv_in   = sat24(mul_p >>> 18);
                  state_in = S_POLY;
               end
            end
         end
         S_POLY: begin
            if (waveform_ff == WAVE_SQUARE) begin
               fmv_in = tri_v;
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd1) begin
               ah_in = mul_p[40:20];
            end else if (cnt_ff >= 3'd2) begin
               num_in = neg2 ? (num_ff - (part <<< 1)) : (num_ff + part);
               if (cnt_ff == 3'd3) begin
                  cnt_in = '0;
                  if (term_ff == ((waveform_ff == WAVE_SQUARE) ? 3'd5 : 3'd2)) begin
                     state_in = S_DEN;
                  end else begin
                     term_in = term_ff + 3'd1;
                  end
               end
            end
         end
         S_DEN: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd1) begin
               den_in   = (nn << 2) + (nn << 1);
               state_in = S_QSTART;
            end
         end
         S_QSTART: begin
            state_in = S_QDIV;
         end
         S_QDIV: begin
            if (div_st.done) begin
               main_in  = sat_quo(num_ff[63], div_quo);
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (fin_go) begin
               rsp_valid_in   = 1'b1;
               rsp_sample_in  = main_ff;
               rsp_fm_in      = fmv_ff;
               rsp_last_in    = last_v;
               rsp_wrapped_in = last_v && wrap_v;
               if (last_v) begin
                  phase_in   = phase_adv;
                  idx_in     = '0;
                  off_acc_in = '0;
               end else begin
                  idx_in     = idx_ff + 1'b1;
                  off_acc_in = off_base + OFF_W'(step_ff);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         waveform_ff  <= WAVE_SINE;
         quality_ff   <= '0;
         fmult_ff     <= 24'd65536;
         period_ff    <= 32'd22906492;
         phase_ff     <= '0;
         idx_ff       <= '0;
         step_ff      <= '0;
         width_ff     <= '0;
         off_acc_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         waveform_ff  <= waveform_in;
         quality_ff   <= quality_in;
         fmult_ff     <= fmult_in;
         period_ff    <= period_in;
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         step_ff      <= step_in;
         width_ff     <= width_in;
         off_acc_ff   <= off_acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff         <= cnt_in;
      term_ff        <= term_in;
      freq_ff        <= freq_in;
      pm_ff          <= pm_in;
      restart_ff     <= restart_in;
      fm_ff          <= fm_in;
      prod_ff        <= prod_in;
      wq_ff          <= wq_in;
      p_ff           <= p_in;
      t2_ff          <= t2_in;
      ah_ff          <= ah_in;
      num_ff         <= num_in;
      den_ff         <= den_in;
      main_ff        <= main_in;
      fmv_ff         <= fmv_in;
      rsp_sample_ff  <= rsp_sample_in;
      rsp_fm_ff      <= rsp_fm_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_wrapped_ff <= rsp_wrapped_in;
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sample    = rsp_sample_ff;
   assign rsp_fm_sample = rsp_fm_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_wrapped   = rsp_wrapped_ff;

   a_wrap_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_wrapped_ff) |-> rsp_last_ff)
      else $error("wrap flagged on a word that does not end a frame");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_st.done |-> (state_ff == S_QDIV))
      else $error("divider finished while no division was awaited");

   a_frame_end_index: assert property (@(posedge clock) disable iff (reset)
      (fin_go && last_v) |=> (idx_ff == '0))
      else $error("subsample index not cleared at frame end");

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> ((state_ff == S_STEP) || (state_ff == S_PHASE)))
      else $error("accepted word did not start processing");

endmodule
